@@ rtl/srw_pkg.sv @@
// ----------------------------------------------------------------------------
// srw_pkg
// Shared constants, types and helpers of the sequence reorder window.
// ----------------------------------------------------------------------------
package srw_pkg;

  // window depth and stored tag width
  localparam int WINDOW      = 32;
  localparam int TAG_BITS    = 16;

  // fixed field widths
  localparam int SEQ_BITS    = 8;
  localparam int HANDLE_BITS = 16;
  localparam int CNT_BITS    = $clog2(WINDOW + 1);
  localparam int SEQ_SPAN    = 1 << SEQ_BITS;

  // distance behind the head above which a number becomes the new head
  localparam logic [SEQ_BITS:0] BEHIND_LIMIT = (SEQ_BITS + 1)'(SEQ_SPAN - WINDOW);

  typedef logic [SEQ_BITS-1:0]    seq_t;
  typedef logic [TAG_BITS-1:0]    tag_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [CNT_BITS-1:0]    cnt_t;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_DUP   = 2'd1,
    STS_FULL  = 2'd2,
    STS_EMPTY = 2'd3
  } status_t;

  // per-cell operation
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POP    = 2'd2
  } cell_op_t;

  // broadcast control to every cell
  typedef struct packed {
    cell_op_t op;
    logic     front;     // new number goes ahead of every entry
    seq_t     key;       // number looked up for a match
    seq_t     head;      // number of the oldest entry
    seq_t     dist_ref;  // distance of the new number from the head
    seq_t     new_seq;
    tag_t     new_tag;
  } cell_ctl_t;

  // contents handed between neighbor cells
  typedef struct packed {
    logic used;
    seq_t seq;
    tag_t tag;
  } cell_data_t;

  // handle port to stored tag
  function automatic tag_t tag_from_handle(handle_t h);
    logic [31:0] w;
    w = 32'(h);
    return w[TAG_BITS-1:0];
  endfunction

  // stored tag to handle port
  function automatic handle_t handle_from_tag(tag_t t);
    logic [31:0] w;
    w = 32'(t);
    return w[HANDLE_BITS-1:0];
  endfunction

endpackage

@@ rtl/srw_cell.sv @@
// ----------------------------------------------------------------------------
// srw_cell
// One slot of the sorted row: holds an entry, matches a key, and takes its
// next entry from itself, its left neighbor, its right neighbor or the input.
// ----------------------------------------------------------------------------
module srw_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  srw_pkg::cell_ctl_t     ctl,
  input  srw_pkg::cell_data_t    left,
  input  srw_pkg::cell_data_t    right,
  input  logic                   left_sfx,
  input  logic                   right_sfx,
  output srw_pkg::cell_data_t    data,
  output logic                   match,
  output logic                   sfx
);

  srw_pkg::seq_t gap;
  logic          le;

  // serial distance from the head and ordering flag
  assign gap   = data.seq - ctl.head;
  assign le    = data.used && (gap <= ctl.dist_ref);
  // some entry at or right of this cell stays ahead of the new number
  assign sfx   = !ctl.front && (le || right_sfx);
  assign match = data.used && (data.seq == ctl.key);

  // entry register, used flag cleared on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      data.used <= 1'b0;
    end else begin
      case (ctl.op)
        srw_pkg::OP_INSERT: begin
          if (!left_sfx) begin
            data <= left;
          end else if (!sfx) begin
            data.used <= 1'b1;
            data.seq  <= ctl.new_seq;
            data.tag  <= ctl.new_tag;
          end
        end
        srw_pkg::OP_POP: begin
          data <= right;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/srw_chain.sv @@
// ----------------------------------------------------------------------------
// srw_chain
// Row of cells kept in serial order, oldest entry in cell zero.
// ----------------------------------------------------------------------------
module srw_chain (
  input  logic                        clk,
  input  logic                        rst,
  input  srw_pkg::cell_ctl_t          ctl,
  output logic                        any_match,
  output srw_pkg::seq_t               head_seq,
  output srw_pkg::tag_t               head_tag,
  output logic [srw_pkg::WINDOW-1:0]  used
);

  srw_pkg::cell_data_t             cdata [srw_pkg::WINDOW];
  srw_pkg::cell_data_t             edge_data;
  logic [srw_pkg::WINDOW-1:0]      match_v;
  logic [srw_pkg::WINDOW-1:0]      sfx_v;

  // empty slot seen beyond either end
  assign edge_data = '{used: 1'b0, seq: '0, tag: '0};

  for (genvar i = 0; i < srw_pkg::WINDOW; i++) begin : g_cell
    srw_pkg::cell_data_t l_data;
    srw_pkg::cell_data_t r_data;
    logic                l_sfx;
    logic                r_sfx;

    // neighbor hookup
    if (i == 0) begin : g_first
      assign l_data = edge_data;
      assign l_sfx  = 1'b1;
    end else begin : g_mid_l
      assign l_data = cdata[i-1];
      assign l_sfx  = sfx_v[i-1];
    end
    if (i == srw_pkg::WINDOW - 1) begin : g_last
      assign r_data = edge_data;
      assign r_sfx  = 1'b0;
    end else begin : g_mid_r
      assign r_data = cdata[i+1];
      assign r_sfx  = sfx_v[i+1];
    end

    srw_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left      (l_data),
      .right     (r_data),
      .left_sfx  (l_sfx),
      .right_sfx (r_sfx),
      .data      (cdata[i]),
      .match     (match_v[i]),
      .sfx       (sfx_v[i])
    );

    assign used[i] = cdata[i].used;
  end

  // row summary
  assign any_match = |match_v;
  assign head_seq  = cdata[0].seq;
  assign head_tag  = cdata[0].tag;

endmodule

@@ rtl/sequence_reorder_window.sv @@
// ----------------------------------------------------------------------------
// sequence_reorder_window
// Receive-side reorder buffer for 8-bit wrapping sequence numbers.
// ----------------------------------------------------------------------------
// Holds up to 32 entries (number and packet tag) in a row of cells kept in
// serial order modulo 256, oldest entry in the first cell. An insert moves the
// row in the cycle it is accepted; a pop shifts every cell toward the head in
// the same way. A pop or a dropped insert goes straight to the done state.
// An accepted insert first passes the stored numbers that the next expected
// number steps over, then goes to the done state: the scan tests one number
// per cycle against all cells at once. From the done state the result word
// is loaded into an output register once that is free; there it waits, and
// the next word is accepted meanwhile. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module sequence_reorder_window (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        cmd,
  input  logic [7:0]  seqnum,
  input  logic [15:0] handle,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic        out_valid,
  output logic [7:0]  out_seqnum,
  output logic [15:0] out_handle,
  output logic [5:0]  stored_count,
  output logic [5:0]  window_free,
  output logic        first_valid,
  output logic [7:0]  first_seqnum,
  output logic [7:0]  next_expected
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                       state;
  state_t                       state_next;
  srw_pkg::cnt_t                count;
  srw_pkg::seq_t                expected;
  srw_pkg::status_t             pend_status;
  logic                         pend_ov;
  srw_pkg::seq_t                pend_seq;
  srw_pkg::tag_t                pend_tag;

  srw_pkg::cell_ctl_t           ctl;
  logic                         any_match;
  srw_pkg::seq_t                head_seq;
  srw_pkg::tag_t                head_tag;
  logic [srw_pkg::WINDOW-1:0]   used;

  logic                         req_fire;
  logic                         is_insert;
  logic                         empty;
  logic                         full;
  logic                         ins_ok;
  logic                         pop_ok;
  logic                         rsp_load;
  srw_pkg::seq_t                dist_in;
  srw_pkg::status_t             status_now;

  // request decode
  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign is_insert = (cmd == srw_pkg::CMD_INSERT);
  assign empty     = (count == '0);
  assign full      = (count == srw_pkg::CNT_BITS'(srw_pkg::WINDOW));
  assign dist_in   = seqnum - head_seq;
  assign ins_ok    = req_fire && is_insert && !any_match && !full;
  assign pop_ok    = req_fire && !is_insert && !empty;

  // status of the accepted word
  always_comb begin
    if (is_insert) begin
      if (any_match) begin
        status_now = srw_pkg::STS_DUP;
      end else if (full) begin
        status_now = srw_pkg::STS_FULL;
      end else begin
        status_now = srw_pkg::STS_OK;
      end
    end else if (empty) begin
      status_now = srw_pkg::STS_EMPTY;
    end else begin
      status_now = srw_pkg::STS_OK;
    end
  end

  // cell row control
  always_comb begin
    ctl.op       = ins_ok ? srw_pkg::OP_INSERT : (pop_ok ? srw_pkg::OP_POP : srw_pkg::OP_HOLD);
    ctl.front    = empty || ({1'b0, dist_in} > srw_pkg::BEHIND_LIMIT);
    ctl.key      = (state == ST_ADV) ? expected : seqnum;
    ctl.head     = head_seq;
    ctl.dist_ref = dist_in;
    ctl.new_seq  = seqnum;
    ctl.new_tag  = srw_pkg::tag_from_handle(handle);
  end

  srw_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .any_match (any_match),
    .head_seq  (head_seq),
    .head_tag  (head_tag),
    .used      (used)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ins_ok ? ST_ADV : ST_DONE;
        end
      end
      ST_ADV: begin
        if (!any_match) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign rsp_load = (state == ST_DONE) && (!rsp_valid || rsp_ready);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      expected  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ins_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok) begin
        count <= count - 1'b1;
      end
      if ((state == ST_ADV) && any_match) begin
        expected <= expected + 1'b1;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // pending result of the accepted word
  always_ff @(posedge clk) begin
    if (req_fire) begin
      pend_status <= status_now;
      pend_ov     <= pop_ok;
      pend_seq    <= pop_ok ? head_seq : '0;
      pend_tag    <= pop_ok ? head_tag : '0;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status        <= pend_status;
      out_valid     <= pend_ov;
      out_seqnum    <= pend_seq;
      out_handle    <= srw_pkg::handle_from_tag(pend_tag);
      stored_count  <= 6'(count);
      window_free   <= 6'(srw_pkg::CNT_BITS'(srw_pkg::WINDOW) - count);
      first_valid   <= !empty;
      first_seqnum  <= empty ? '0 : head_seq;
      next_expected <= expected;
    end
  end

  // count never passes the window
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= srw_pkg::CNT_BITS'(srw_pkg::WINDOW))
    else $error("entry count beyond window");

  // used cells agree with the count
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(count))
    else $error("used cells disagree with entry count");

  // an insert that is kept adds exactly one entry
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ins_ok |=> (count == $past(count) + 1'b1) && (state == ST_ADV))
    else $error("insert did not add one entry");

  // a pop on a nonempty row removes exactly one entry
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop_ok |=> (count == $past(count) - 1'b1) && (state == ST_DONE))
    else $error("pop did not remove one entry");

endmodule
